>>> design/hcb_pkg.sv
// hcb_pkg: shared constants and types for the huffman code builder
// depends on nothing; imported by every module in the design folder
`timescale 1ns / 1ps

package hcb_pkg;

	localparam int MAX_SYMBOLS = 32;
	localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS - 1;
	localparam int NID_W       = $clog2(NODE_SLOTS);
	localparam int LID_W       = $clog2(MAX_SYMBOLS);
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int SYM_W       = 8;
	localparam int WEIGHT_W    = 20;
	localparam int NWEIGHT_W   = 26;
	localparam int CODE_W      = 63;
	localparam int LEN_W       = 6;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 80;

	// two lightest nodes seen so far, carried along the node chain
	typedef struct packed {
		logic                 tok;
		logic                 v1;
		logic [NID_W-1:0]     i1;
		logic [NWEIGHT_W-1:0] w1;
		logic                 v2;
		logic [NID_W-1:0]     i2;
		logic [NWEIGHT_W-1:0] w2;
	} cand_t;

	typedef struct packed {
		logic                 clear;
		logic                 load_en;
		logic [NID_W-1:0]     load_idx;
		logic [WEIGHT_W-1:0]  load_weight;
		logic                 merge_en;
		logic [NID_W-1:0]     made;
		logic [NID_W-1:0]     a;
		logic [NID_W-1:0]     b;
		logic [NWEIGHT_W-1:0] wsum;
	} node_cmd_t;

	typedef struct packed {
		logic             load_en;
		logic [LID_W-1:0] load_idx;
		logic [SYM_W-1:0] load_sym;
		logic             merge_en;
		logic [NID_W-1:0] made;
		logic [NID_W-1:0] a;
		logic [NID_W-1:0] b;
		logic             shift;
	} leaf_cmd_t;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [NID_W-1:0]  grp;
	} leaf_t;

endpackage

>>> design/hcb_node_cell.sv
// hcb_node_cell: one tree node slot, weight and active flag, plus one stage
// of the two-smallest search chain; uses hcb_pkg
`timescale 1ns / 1ps

module hcb_node_cell
	import hcb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NID_W-1:0] cell_id,
	input  node_cmd_t        cmd,
	input  cand_t            cand_in,
	output cand_t            cand_out
);

	logic                 active_q;
	logic [NWEIGHT_W-1:0] weight_q;
	cand_t                cand_q;
	cand_t                cand_nxt;

	always_comb begin
		cand_nxt = cand_in;
		if (active_q) begin
			if (!cand_in.v1 || weight_q < cand_in.w1) begin
				cand_nxt.v2 = cand_in.v1;
				cand_nxt.i2 = cand_in.i1;
				cand_nxt.w2 = cand_in.w1;
				cand_nxt.v1 = 1'b1;
				cand_nxt.i1 = cell_id;
				cand_nxt.w1 = weight_q;
			end else if (!cand_in.v2 || weight_q < cand_in.w2) begin
				cand_nxt.v2 = 1'b1;
				cand_nxt.i2 = cell_id;
				cand_nxt.w2 = weight_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cand_q   <= '0;
		end else begin
			cand_q <= cand_nxt;
			if (cmd.clear) begin
				active_q <= 1'b0;
			end else if (cmd.load_en && cmd.load_idx == cell_id) begin
				active_q <= 1'b1;
			end else if (cmd.merge_en && cmd.made == cell_id) begin
				active_q <= 1'b1;
			end else if (cmd.merge_en && (cmd.a == cell_id || cmd.b == cell_id)) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && cmd.load_idx == cell_id) begin
			weight_q <= NWEIGHT_W'(cmd.load_weight);
		end else if (cmd.merge_en && cmd.made == cell_id) begin
			weight_q <= cmd.wsum;
		end
	end

	assign cand_out = cand_q;

endmodule

>>> design/hcb_leaf_cell.sv
// hcb_leaf_cell: one loaded symbol with its growing code, length and the
// tree node it currently hangs under; shifts toward cell 0 on output; uses hcb_pkg
`timescale 1ns / 1ps

module hcb_leaf_cell
	import hcb_pkg::*;
(
	input  logic             clk,
	input  logic [LID_W-1:0] cell_id,
	input  leaf_cmd_t        cmd,
	input  leaf_t            next,
	output leaf_t            cur
);

	leaf_t leaf_q;

	always_ff @(posedge clk) begin
		if (cmd.load_en && cmd.load_idx == cell_id) begin
			leaf_q.sym  <= cmd.load_sym;
			leaf_q.code <= '0;
			leaf_q.len  <= '0;
			leaf_q.grp  <= NID_W'(cell_id);
		end else if (cmd.merge_en && leaf_q.grp == cmd.a) begin
			leaf_q.len <= leaf_q.len + 1'b1;
			leaf_q.grp <= cmd.made;
		end else if (cmd.merge_en && leaf_q.grp == cmd.b) begin
			leaf_q.code <= leaf_q.code | (CODE_W'(1) << leaf_q.len);
			leaf_q.len  <= leaf_q.len + 1'b1;
			leaf_q.grp  <= cmd.made;
		end else if (cmd.shift) begin
			leaf_q <= next;
		end
	end

	assign cur = leaf_q;

endmodule

>>> design/huffman_code_builder.sv
// huffman_code_builder: top level, load control, merge sequencer and output
// depends on hcb_pkg, hcb_node_cell, hcb_leaf_cell
//
// channel  dir  fields (low bit first)
// s_*      in   tdata: symbol[7:0] weight[27:8]; tlast: last
// m_*      out  tdata: symbol_out[7:0] code_bits[70:8] code_length[76:71]; tuser: dropped;
//               tlast: last_out
//
// loading takes one cycle per transfer
// each merge sends one search token down the node chain, and there are
// n - 1 merges for n symbols, then one result per cycle while m_tready is high
// s_tready is low from the final input transfer until the final result transfer
// reset clears the control state and all node active flags
`timescale 1ns / 1ps

module huffman_code_builder
	import hcb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // symbol, weight, zero fill
	input  logic                  s_tlast,   // last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // symbol_out, code_bits, code_length, zero fill
	output logic                  m_tlast,   // last_out
	output logic                  m_tuser    // dropped
);

	typedef enum logic [1:0] {ST_LOAD, ST_START, ST_WAIT, ST_EMIT} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] n_q;
	logic [NID_W-1:0] made_q;
	logic [NID_W-1:0] root_q;
	logic [CNT_W-1:0] emit_q;

	node_cmd_t        ncmd;
	leaf_cmd_t        lcmd;
	cand_t            cand [NODE_SLOTS+1];
	leaf_t            leaf [MAX_SYMBOLS+1];

	logic             s_xfer;
	logic             m_xfer;
	logic             room;
	logic [CNT_W-1:0] new_n;
	logic             merge_now;
	cand_t            res;

	assign s_tready  = (state_q == ST_LOAD);
	assign s_xfer    = s_tvalid && s_tready;
	assign m_tvalid  = (state_q == ST_EMIT);
	assign m_xfer    = m_tvalid && m_tready;
	assign room      = (count_q < CNT_W'(MAX_SYMBOLS));
	assign new_n     = room ? count_q + 1'b1 : count_q;
	assign res       = cand[NODE_SLOTS];
	assign merge_now = (state_q == ST_WAIT) && res.tok;

	always_comb begin
		cand[0]     = '0;
		cand[0].tok = (state_q == ST_START);

		ncmd             = '0;
		ncmd.clear       = m_xfer && m_tlast;
		ncmd.load_en     = s_xfer && room;
		ncmd.load_idx    = NID_W'(count_q);
		ncmd.load_weight = s_tdata[SYM_W +: WEIGHT_W];
		ncmd.merge_en    = merge_now;
		ncmd.made        = made_q;
		ncmd.a           = res.i1;
		ncmd.b           = res.i2;
		ncmd.wsum        = res.w1 + res.w2;

		lcmd          = '0;
		lcmd.load_en  = s_xfer && room;
		lcmd.load_idx = count_q[LID_W-1:0];
		lcmd.load_sym = s_tdata[SYM_W-1:0];
		lcmd.merge_en = merge_now;
		lcmd.made     = made_q;
		lcmd.a        = res.i1;
		lcmd.b        = res.i2;
		lcmd.shift    = m_xfer;
	end

	for (genvar j = 0; j < NODE_SLOTS; j++) begin : g_node
		hcb_node_cell u_node (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (NID_W'(j)),
			.cmd      (ncmd),
			.cand_in  (cand[j]),
			.cand_out (cand[j+1])
		);
	end

	assign leaf[MAX_SYMBOLS] = '0;

	for (genvar j = 0; j < MAX_SYMBOLS; j++) begin : g_leaf
		hcb_leaf_cell u_leaf (
			.clk     (clk),
			.cell_id (LID_W'(j)),
			.cmd     (lcmd),
			.next    (leaf[j+1]),
			.cur     (leaf[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			made_q  <= '0;
			root_q  <= '0;
			emit_q  <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (s_xfer) begin
						count_q <= new_n;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							n_q    <= new_n;
							made_q <= NID_W'(new_n);
							root_q <= NID_W'(2 * int'(new_n) - 2);
							emit_q <= '0;
							state_q <= (new_n == CNT_W'(1)) ? ST_EMIT : ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (res.tok) begin
						made_q  <= made_q + 1'b1;
						state_q <= (made_q == root_q) ? ST_EMIT : ST_START;
					end
				end
				ST_EMIT: begin
					if (m_xfer) begin
						emit_q <= emit_q + 1'b1;
						if (m_tlast) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tdata = {3'b000, leaf[0].len, leaf[0].code, leaf[0].sym};
	assign m_tlast = (emit_q == n_q - 1'b1);
	assign m_tuser = ovf_q;

endmodule

>>> tb/tb_huffman_code_builder.sv
// tb_huffman_code_builder: streaming testbench for the huffman code builder
// depends on hcb_pkg and huffman_code_builder; predicts codes per set and checks every result
`timescale 1ns / 1ps

module tb_huffman_code_builder;
	import hcb_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0]    sym;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
	} pair_t;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              dropped;
		logic              last;
	} code_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	pair_t pending_pairs[$];
	code_t expected_codes[$];
	int    pause_marks[$];

	// predictor state
	logic [SYM_W-1:0]     set_sym[MAX_SYMBOLS];
	logic [WEIGHT_W-1:0]  set_weight[MAX_SYMBOLS];
	int                   set_count;
	logic                 set_overflow;

	int mismatches;
	int cycle_count;
	int sent_count;
	int burst_left;
	int gap_left;
	int stall_phase;

	huffman_code_builder i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic build_codes();
		logic [NWEIGHT_W-1:0] nw[NODE_SLOTS];
		int                   par[NODE_SLOTS];
		bit                   side[NODE_SLOTS];
		bit                   act[NODE_SLOTS];
		int n, made, a, b, node, len, root;
		logic [CODE_W-1:0] code;
		code_t r;
		n = set_count;
		for (int i = 0; i < NODE_SLOTS; i++) act[i] = 1'b0;
		for (int i = 0; i < n; i++) begin
			nw[i] = NWEIGHT_W'(set_weight[i]);
			act[i] = 1'b1;
		end
		for (int k = 0; k + 1 < n; k++) begin
			made = n + k;
			a = made;
			for (int i = 0; i < made; i++)
				if (act[i] && (a == made || nw[i] < nw[a])) a = i;
			act[a] = 1'b0;
			b = made;
			for (int i = 0; i < made; i++)
				if (act[i] && (b == made || nw[i] < nw[b])) b = i;
			act[b] = 1'b0;
			nw[made] = nw[a] + nw[b];
			par[a] = made;
			side[a] = 1'b0;
			par[b] = made;
			side[b] = 1'b1;
			act[made] = 1'b1;
		end
		root = 2 * n - 2;
		for (int i = 0; i < n; i++) begin
			code = '0;
			len = 0;
			node = i;
			while (node != root && len < 63) begin
				code[len] = side[node];
				len++;
				node = par[node];
			end
			r.sym = set_sym[i];
			r.code = code;
			r.len = len[LEN_W-1:0];
			r.dropped = set_overflow;
			r.last = (i + 1 == n);
			expected_codes.push_back(r);
		end
		set_count = 0;
		set_overflow = 1'b0;
	endtask

	task automatic accept_pair(input pair_t p);
		if (set_count < MAX_SYMBOLS) begin
			set_sym[set_count] = p.sym;
			set_weight[set_count] = p.weight;
			set_count++;
		end else begin
			set_overflow = 1'b1;
		end
		if (p.last) build_codes();
	endtask

	function automatic pair_t mk(input int s, input int w, input bit l);
		pair_t p;
		p.sym = SYM_W'(s);
		p.weight = WEIGHT_W'(w);
		p.last = l;
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
			sent_count <= 0;
		end else begin
			automatic bit busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				accept_pair(pending_pairs.pop_front());
				sent_count <= sent_count + 1;
				busy = 0;
			end
			if (!busy) begin
				automatic bit go = 0;
				if (pending_pairs.size() > 0 && !(pause_marks.size() > 0
						&& pause_marks[0] <= sent_count + (s_tvalid && s_tready))) begin
					if (burst_left > 0) begin
						go = 1;
						burst_left <= burst_left - 1;
					end else if (gap_left > 0) begin
						gap_left <= gap_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
					end
				end else if (pause_marks.size() > 0 && expected_codes.size() == 0
						&& !m_tvalid) begin
					void'(pause_marks.pop_front());
				end
				if (go) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_pairs[0].weight, pending_pairs[0].sym};
					s_tlast <= pending_pairs[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
			mismatches <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			m_tready <= (stall_phase[8:7] == 2'd0) ? 1'b1 :
				(stall_phase % 5 != 2) && ($urandom_range(0, 3) != 0);
			if (m_tvalid && m_tready) begin
				if (expected_codes.size() == 0) begin
					if (mismatches < 10) $display("unexpected transfer %h", m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					automatic code_t e = expected_codes.pop_front();
					automatic code_t g;
					g.sym = m_tdata[7:0];
					g.code = m_tdata[70:8];
					g.len = m_tdata[76:71];
					g.dropped = m_tuser;
					g.last = m_tlast;
					if (g !== e) begin
						if (mismatches < 10)
							$display("mismatch exp sym %h code %h len %0d drop %b last %b / got sym %h code %h len %0d drop %b last %b",
								e.sym, e.code, e.len, e.dropped, e.last,
								g.sym, g.code, g.len, g.dropped, g.last);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int n, total;
		cycle_count = 0;
		set_count = 0;
		set_overflow = 1'b0;
		// directed sets
		pending_pairs.push_back(mk(8'h24, 5, 1));
		pending_pairs.push_back(mk(8'h00, 0, 0));
		pending_pairs.push_back(mk(8'hff, 20'hfffff, 1));
		pending_pairs.push_back(mk(8'h24, 7, 0));
		pending_pairs.push_back(mk(8'h24, 7, 0));
		pending_pairs.push_back(mk(8'h55, 7, 0));
		pending_pairs.push_back(mk(8'haa, 20'hfffff, 1));
		pending_pairs.push_back(mk(8'h01, 1, 0));
		pending_pairs.push_back(mk(8'h02, 2, 0));
		pending_pairs.push_back(mk(8'h03, 4, 0));
		pending_pairs.push_back(mk(8'h04, 8, 0));
		pending_pairs.push_back(mk(8'h05, 16, 1));
		pause_marks.push_back(pending_pairs.size());
		// overflow set: 34 pairs, last carried by a dropped one
		for (int i = 0; i < 34; i++)
			pending_pairs.push_back(mk($urandom_range(0, 255), 20'hfffff - i, i == 33));
		pause_marks.push_back(pending_pairs.size());
		// fibonacci weights for a deep tree
		begin
			int f0, f1, t;
			f0 = 1;
			f1 = 1;
			for (int i = 0; i < 28; i++) begin
				pending_pairs.push_back(mk(i, f0, i == 27));
				t = f0 + f1;
				f0 = f1;
				f1 = t;
			end
		end
		// random sets
		total = 0;
		while (total < 136) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 10);
			for (int i = 0; i < n; i++) begin
				automatic int w;
				case ($urandom_range(0, 3))
					0: w = $urandom_range(0, 3);
					1: w = $urandom_range(0, 20'hfffff);
					2: w = 20'hfffff;
					default: w = $urandom_range(0, 100);
				endcase
				pending_pairs.push_back(mk($urandom_range(0, 255), w, i == n - 1));
			end
			total += n;
			if ($urandom_range(0, 9) == 0) pause_marks.push_back(pending_pairs.size());
		end
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pairs.size() == 0 && !s_tvalid);
		wait (expected_codes.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_codes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
